[hw/rtl/bilp_pkg.sv]
// Shared types, constants and helper functions of the bracketed integer list parser.
package bilp_pkg;

   // Element width and the derived arithmetic widths.
   localparam int VALUE_BITS = 32;
   localparam int ELEM_BITS  = 32;
   localparam int CHAR_BITS  = 8;
   localparam int WIDE_BITS  = (VALUE_BITS > ELEM_BITS) ? VALUE_BITS : ELEM_BITS;
   localparam int MUL_BITS   = VALUE_BITS + 4;

   // Character codes.
   localparam logic [CHAR_BITS-1:0] CH_OPEN  = 8'h5B;
   localparam logic [CHAR_BITS-1:0] CH_CLOSE = 8'h5D;
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;

   // Element limits, held at the width of the multiply-by-ten sum.
   localparam logic [MUL_BITS-1:0] LIM_UNSIGNED = (MUL_BITS'(1) << VALUE_BITS) - MUL_BITS'(1);
   localparam logic [MUL_BITS-1:0] LIM_SIGNED_POS =
      (MUL_BITS'(1) << (VALUE_BITS - 1)) - MUL_BITS'(1);
   localparam logic [MUL_BITS-1:0] LIM_SIGNED_NEG = MUL_BITS'(1) << (VALUE_BITS - 1);

   typedef enum logic [2:0] {
      PH_OPEN   = 3'd0,
      PH_LIST   = 3'd1,
      PH_SIGN   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_CLOSED = 3'd4,
      PH_ERROR  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_OPEN     = 3'd1,
      ST_DIGIT    = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_TRAILING = 3'd4
   } status_type;

   typedef struct packed {
      logic [ELEM_BITS-1:0] element_value;
      logic                 element_valid;
      logic                 list_closed;
      logic                 stream_done;
      status_type           status;
   } rsp_type;

   function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
      return (c == CH_TAB) || (c == CH_CR) || (c == CH_SPACE);
   endfunction

   function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Negate if needed, sign-extend in signed mode or after a minus, cut to the port width.
   function automatic logic [ELEM_BITS-1:0] element_bits(input logic [VALUE_BITS-1:0] acc,
                                                          input logic neg,
                                                          input logic mode);
      logic [VALUE_BITS-1:0] v;
      logic [WIDE_BITS-1:0]  ext;
      v = neg ? (VALUE_BITS'(0) - acc) : acc;
      if (mode || neg) begin
         ext = WIDE_BITS'($signed(v));
      end else begin
         ext = WIDE_BITS'(v);
      end
      return ext[ELEM_BITS-1:0];
   endfunction

endpackage

[hw/rtl/bilp_parse.sv]
// Parse state registers and the per-character transition logic.
module bilp_parse import bilp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 signed_mode,
   input  logic                 beat_accept,
   input  logic [CHAR_BITS-1:0] char_code,
   input  logic                 end_of_stream,
   output rsp_type              result,
   output logic                 result_valid
);

   phase_type             phase_ff, phase_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   status_type            err_ff, err_in;

   // Outcome of a character seen between elements, with the element state cleared.
   phase_type             lc_phase;
   logic [VALUE_BITS-1:0] lc_acc;
   logic                  lc_neg;
   status_type            lc_err;
   logic                  lc_close;

   logic [3:0]            digit;
   logic [MUL_BITS-1:0]   limit;
   logic [MUL_BITS-1:0]   scaled;
   logic                  overflow;

   assign digit = 4'(char_code - CH_ZERO);

   // Next accumulator value and the overflow check against the active limit.
   always_comb begin
      if (signed_mode) begin
         limit = neg_ff ? LIM_SIGNED_NEG : LIM_SIGNED_POS;
      end else begin
         limit = LIM_UNSIGNED;
      end
      scaled = (MUL_BITS'(acc_ff) << 3) + (MUL_BITS'(acc_ff) << 1) + MUL_BITS'(digit);
      overflow = scaled > limit;
   end

   // Character handling between elements.
   always_comb begin
      lc_phase = PH_LIST;
      lc_acc   = '0;
      lc_neg   = 1'b0;
      lc_err   = err_ff;
      lc_close = 1'b0;
      if (is_blank(char_code)) begin
         lc_phase = PH_LIST;
      end else if (char_code == CH_CLOSE) begin
         lc_phase = PH_CLOSED;
         lc_close = 1'b1;
      end else if (signed_mode && ((char_code == CH_PLUS) || (char_code == CH_MINUS))) begin
         lc_neg   = (char_code == CH_MINUS);
         lc_phase = PH_SIGN;
      end else if (is_digit(char_code)) begin
         lc_acc   = VALUE_BITS'(digit);
         lc_phase = PH_DIGITS;
      end else begin
         lc_phase = PH_ERROR;
         lc_err   = ST_DIGIT;
      end
   end

   // Main transition and result formation.
   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      result       = '0;
      result_valid = 1'b0;
      if (end_of_stream) begin
         result_valid = 1'b1;
         case (phase_ff)
            PH_OPEN: result.status = ST_OPEN;
            PH_DIGITS: begin
               result.element_value = element_bits(acc_ff, neg_ff, signed_mode);
               result.element_valid = 1'b1;
               result.status        = ST_DIGIT;
            end
            PH_CLOSED: begin
               result.status      = ST_OK;
               result.stream_done = 1'b1;
            end
            PH_ERROR: result.status = err_ff;
            default:  result.status = ST_DIGIT;
         endcase
         phase_in = PH_OPEN;
         acc_in   = '0;
         neg_in   = 1'b0;
      end else begin
         case (phase_ff)
            PH_OPEN: begin
               if (char_code == CH_OPEN) begin
                  phase_in = PH_LIST;
               end else if (!is_blank(char_code)) begin
                  phase_in = PH_ERROR;
                  err_in   = ST_OPEN;
                  neg_in   = 1'b0;
               end
            end
            PH_LIST: begin
               phase_in            = lc_phase;
               acc_in              = (lc_phase == PH_DIGITS) ? lc_acc : acc_ff;
               neg_in              = ((lc_phase == PH_SIGN) || (lc_phase == PH_DIGITS) ||
                                      (lc_phase == PH_ERROR)) ? lc_neg : neg_ff;
               err_in              = lc_err;
               result.list_closed  = lc_close;
               result_valid        = lc_close;
            end
            PH_SIGN: begin
               if (is_digit(char_code)) begin
                  acc_in   = VALUE_BITS'(digit);
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_ERROR;
                  err_in   = ST_DIGIT;
                  neg_in   = 1'b0;
               end
            end
            PH_DIGITS: begin
               if (is_digit(char_code)) begin
                  if (overflow) begin
                     phase_in = PH_ERROR;
                     err_in   = ST_OVERFLOW;
                     neg_in   = 1'b0;
                  end else begin
                     acc_in = scaled[VALUE_BITS-1:0];
                  end
               end else begin
                  // The terminator ends the element and is then parsed as a list character.
                  result.element_value = element_bits(acc_ff, neg_ff, signed_mode);
                  result.element_valid = 1'b1;
                  result.list_closed   = lc_close;
                  result_valid         = 1'b1;
                  phase_in             = lc_phase;
                  acc_in               = lc_acc;
                  neg_in               = lc_neg;
                  err_in               = lc_err;
               end
            end
            PH_CLOSED: begin
               phase_in = PH_ERROR;
               err_in   = ST_TRAILING;
               neg_in   = 1'b0;
            end
            PH_ERROR: begin
               phase_in = PH_ERROR;
            end
            default: begin
               phase_in = PH_ERROR;
               err_in   = ST_DIGIT;
               neg_in   = 1'b0;
            end
         endcase
      end
   end

   // State registers advance on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPEN;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         err_ff   <= ST_OK;
      end else if (beat_accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         err_ff   <= err_in;
      end
   end

endmodule

[hw/rtl/bilp_rsp_buf.sv]
// Two-entry result buffer that decouples the parser from the result channel.
module bilp_rsp_buf import bilp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   input  logic    pop,
   output logic    out_valid,
   output rsp_type out_data
);

   localparam logic [1:0] FULL_COUNT = 2'd2;

   rsp_type    ent_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;

   assign space     = (cnt_ff != FULL_COUNT);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = ent_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   // Entry storage is payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

[hw/rtl/bracketed_integer_list_parser.sv]
// Top level of the bracketed decimal integer list parser.
//
//   Channel   Direction  Payload
//   req_*     in         tdata[7:0] char_code, tlast end_of_stream
//   rsp_*     out        tdata element_value/stream_done/status, tuser element_valid,
//                        tlast list_closed
//   csr_*     in         csr_data signed_mode
//
// Each character beat is parsed in the cycle it is accepted; its result, if any,
// is written into the result buffer that drives the result channel.
// One beat per cycle while the buffer has space; x10 and limit compare are combinational.
// Reset returns the parser to expecting an open bracket and sets signed mode.
// The request side stalls only when both entries of the result buffer are occupied.
module bracketed_integer_list_parser import bilp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [CHAR_BITS-1:0] req_tdata,   // [7:0] char_code
   input  logic                 req_tlast,   // end_of_stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // [31:0] element_value, [32] stream_done,
                                             // [35:33] status, [39:36] zero
   output logic                 rsp_tuser,   // element_valid
   output logic                 rsp_tlast,   // list_closed
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data     // signed_mode
);

   logic    signed_mode_ff;
   logic    req_accept;
   logic    res_valid;
   rsp_type res;
   rsp_type rsp;
   logic    buf_space;

   assign csr_ready  = 1'b1;
   assign req_tready = buf_space;
   assign req_accept = req_tvalid && req_tready;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         signed_mode_ff <= csr_data;
      end
   end

   bilp_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .signed_mode   (signed_mode_ff),
      .beat_accept   (req_accept),
      .char_code     (req_tdata),
      .end_of_stream (req_tlast),
      .result        (res),
      .result_valid  (res_valid)
   );

   bilp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && res_valid),
      .push_data (res),
      .space     (buf_space),
      .pop       (rsp_tvalid && rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp)
   );

   // Result beat packing.
   assign rsp_tdata = {4'b0000, rsp.status, rsp.stream_done, rsp.element_value};
   assign rsp_tuser = rsp.element_valid;
   assign rsp_tlast = rsp.list_closed;

   // An accepted end beat always yields a result.
   a_end_yields_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("end beat produced no result");

   // A successful stream end carries an ok status.
   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[32]) |-> (rsp_tdata[35:33] == ST_OK))
      else $error("stream done with nonzero status");

   // A closing bracket result is never an end result.
   a_close_not_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (!rsp_tdata[32] && (rsp_tdata[35:33] == ST_OK)))
      else $error("list close mixed with end result");

   // Without an element the value field is zero.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("value present without element");

endmodule
